// ----- hdl/rsa_pkg.sv -----
// ----------------------------------------------------------------------------
// rsa_pkg
// Shared types and constants of the region spectrum accumulator.
// ----------------------------------------------------------------------------
package rsa_pkg;

  localparam int BINS  = 16384;
  localparam int BIN_W = $clog2(BINS);

  localparam int FIFO_DEPTH = 3;
  localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic signed [31:0] POS_X_CODE      = 32'sd50000000;
  localparam logic signed [32:0] POS_Y_CODE      = 33'sd60000000;
  localparam logic signed [31:0] WORD_PIXEL_END  = -32'sd1;
  localparam logic signed [31:0] WORD_STREAM_END = -32'sd2;

  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_STREAM = 2'd1;
  localparam logic [1:0] FUNC_READ   = 2'd2;

  localparam logic [1:0] CFG_X_LOW  = 2'd0;
  localparam logic [1:0] CFG_X_HIGH = 2'd1;
  localparam logic [1:0] CFG_Y_LOW  = 2'd2;
  localparam logic [1:0] CFG_Y_HIGH = 2'd3;

  localparam logic KIND_BIN = 1'b0;
  localparam logic KIND_EOS = 1'b1;

  typedef enum logic [2:0] {
    PH_SEEK,
    PH_Y,
    PH_SKIP,
    PH_COUNT,
    PH_CHAN,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLEAR,
    OP_ADD,
    OP_READ,
    OP_READ_ZERO,
    OP_EOS
  } op_t;

  typedef struct packed {
    logic              valid;
    op_t               op;
    logic [BIN_W-1:0]  addr;
    logic [31:0]       count;
  } req_t;

  typedef struct packed {
    logic        valid;
    logic        kind;
    logic [31:0] value;
  } res_t;

  typedef struct packed {
    logic busy;
    logic res_pending;
  } stat_t;

endpackage

// ----- hdl/rsa_if.sv -----
// ----------------------------------------------------------------------------
// rsa_if
// Valid/ready channels of the region spectrum accumulator.
// ----------------------------------------------------------------------------
interface rsa_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic signed [31:0] word;
  logic [13:0]        bin_index;

  modport source (output valid, func, word, bin_index, input ready);
  modport sink   (input valid, func, word, bin_index, output ready);
endinterface

interface rsa_out_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [31:0] bin_value;

  modport source (output valid, kind, bin_value, input ready);
  modport sink   (input valid, kind, bin_value, output ready);
endinterface

interface rsa_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [11:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/rsa_parser.sv -----
// ----------------------------------------------------------------------------
// rsa_parser
// Rectangle registers and pixel record parser; issues one store request per
// accepted word.
// ----------------------------------------------------------------------------
module rsa_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [11:0]        cfg_data,
  input  logic               accept,
  input  logic [1:0]         func,
  input  logic signed [31:0] word,
  input  logic [13:0]        bin_index,
  output rsa_pkg::req_t      req
);
  import rsa_pkg::*;

  logic [11:0] x_low_r, x_high_r, y_low_r, y_high_r;
  phase_t      phase_r, phase_nxt;
  logic        x_in_r, x_in_nxt;
  logic        sel_r, sel_nxt;
  logic [31:0] held_r, held_nxt;

  logic [11:0]        x_lo, x_hi, y_lo, y_hi;
  logic [31:0]        x_diff;
  logic signed [32:0] y_diff;
  logic               x_inside, y_inside, single_pt, chan_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_low_r  <= '0;
      x_high_r <= '0;
      y_low_r  <= '0;
      y_high_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_X_LOW:  x_low_r  <= cfg_data;
        CFG_X_HIGH: x_high_r <= cfg_data;
        CFG_Y_LOW:  y_low_r  <= cfg_data;
        CFG_Y_HIGH: y_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEEK;
      x_in_r  <= 1'b0;
      sel_r   <= 1'b0;
      held_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      x_in_r  <= x_in_nxt;
      sel_r   <= sel_nxt;
      held_r  <= held_nxt;
    end
  end

  assign x_lo      = (x_low_r < x_high_r) ? x_low_r : x_high_r;
  assign x_hi      = (x_low_r < x_high_r) ? x_high_r : x_low_r;
  assign y_lo      = (y_low_r < y_high_r) ? y_low_r : y_high_r;
  assign y_hi      = (y_low_r < y_high_r) ? y_high_r : y_low_r;
  assign x_diff    = 32'(word - POS_X_CODE);
  assign y_diff    = $signed({word[31], word}) - POS_Y_CODE;
  assign x_inside  = (x_diff >= {20'd0, x_lo}) && (x_diff <= {20'd0, x_hi});
  assign y_inside  = !y_diff[32] && (y_diff[31:0] >= {20'd0, y_lo}) &&
                     (y_diff[31:0] <= {20'd0, y_hi});
  assign single_pt = (x_low_r == x_high_r) && (y_low_r == y_high_r);
  assign chan_ok   = !word[31] && (word[30:0] < 31'(BINS));

  always_comb begin
    phase_nxt = phase_r;
    x_in_nxt  = x_in_r;
    sel_nxt   = sel_r;
    held_nxt  = held_r;
    req.valid = accept;
    req.op    = OP_NONE;
    req.addr  = BIN_W'(bin_index);
    req.count = held_r;
    if (accept) begin
      case (func)
        FUNC_CLEAR: begin
          req.op    = OP_CLEAR;
          phase_nxt = PH_SEEK;
          x_in_nxt  = 1'b0;
          sel_nxt   = 1'b0;
          held_nxt  = '0;
        end
        FUNC_READ: begin
          req.op = (32'(bin_index) < 32'(BINS)) ? OP_READ : OP_READ_ZERO;
        end
        FUNC_STREAM: begin
          case (phase_r)
            PH_SEEK: begin
              if (word == WORD_STREAM_END) begin
                phase_nxt = PH_DONE;
                req.op    = OP_EOS;
              end else if (word > POS_X_CODE) begin
                x_in_nxt  = x_inside;
                phase_nxt = PH_Y;
              end
            end
            PH_Y: begin
              sel_nxt   = x_in_r && y_inside;
              phase_nxt = PH_SKIP;
            end
            PH_SKIP: begin
              phase_nxt = sel_r ? PH_COUNT : PH_SEEK;
            end
            PH_COUNT: begin
              if (word == WORD_PIXEL_END) begin
                if (single_pt) begin
                  phase_nxt = PH_DONE;
                  req.op    = OP_EOS;
                end else begin
                  phase_nxt = PH_SEEK;
                end
              end else begin
                held_nxt  = word;
                phase_nxt = PH_CHAN;
              end
            end
            PH_CHAN: begin
              if (chan_ok) begin
                req.op   = OP_ADD;
                req.addr = word[BIN_W-1:0];
              end
              phase_nxt = PH_COUNT;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- hdl/rsa_bin_store.sv -----
// ----------------------------------------------------------------------------
// rsa_bin_store
// Spectrum memory with read-modify-write stage, write forwarding and the
// clearing sweep.
// ----------------------------------------------------------------------------
module rsa_bin_store (
  input  logic           clk,
  input  logic           rst_n,
  input  rsa_pkg::req_t  req,
  output rsa_pkg::res_t  res,
  output rsa_pkg::stat_t stat
);
  import rsa_pkg::*;

  logic [31:0]      mem [BINS];
  logic [31:0]      mem_q_r;
  req_t             s2_r;
  logic             clr_active_r;
  logic [BIN_W-1:0] clr_addr_r;
  logic             fwd_valid_r;
  logic [BIN_W-1:0] fwd_addr_r;
  logic [31:0]      fwd_data_r;

  logic             s2_add;
  logic [31:0]      cur;
  logic [31:0]      sum;
  logic             wr_en;
  logic [BIN_W-1:0] wr_addr;
  logic [31:0]      wr_data;

  assign s2_add  = s2_r.valid && (s2_r.op == OP_ADD);
  assign cur     = (fwd_valid_r && (fwd_addr_r == s2_r.addr)) ? fwd_data_r : mem_q_r;
  assign sum     = cur + s2_r.count;
  assign wr_en   = clr_active_r || s2_add;
  assign wr_addr = clr_active_r ? clr_addr_r : s2_r.addr;
  assign wr_data = clr_active_r ? 32'd0 : sum;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q_r <= mem[req.addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r         <= '0;
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      fwd_valid_r  <= 1'b0;
    end else begin
      s2_r        <= req;
      fwd_valid_r <= s2_add && !clr_active_r;
      if (clr_active_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == BIN_W'(BINS - 1)) begin
          clr_active_r <= 1'b0;
        end
      end else if (req.valid && (req.op == OP_CLEAR)) begin
        clr_active_r <= 1'b1;
        clr_addr_r   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr_r <= s2_r.addr;
    fwd_data_r <= sum;
  end

  always_comb begin
    res.valid = 1'b0;
    res.kind  = KIND_BIN;
    res.value = '0;
    if (s2_r.valid) begin
      case (s2_r.op)
        OP_READ: begin
          res.valid = 1'b1;
          res.value = cur;
        end
        OP_READ_ZERO: res.valid = 1'b1;
        OP_EOS: begin
          res.valid = 1'b1;
          res.kind  = KIND_EOS;
        end
        default: ;
      endcase
    end
  end

  assign stat.busy        = clr_active_r;
  assign stat.res_pending = res.valid;

endmodule

// ----- hdl/rsa_out_fifo.sv -----
// ----------------------------------------------------------------------------
// rsa_out_fifo
// Small result queue that decouples the store pipeline from the receiver.
// ----------------------------------------------------------------------------
module rsa_out_fifo (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rsa_pkg::res_t          push,
  output logic [rsa_pkg::FIFO_CW-1:0] count,
  rsa_out_if.source              out_ch
);
  import rsa_pkg::*;

  logic               kind_r  [FIFO_DEPTH];
  logic [31:0]        value_r [FIFO_DEPTH];
  logic [FIFO_PW-1:0] head_r, tail_r;
  logic [FIFO_CW-1:0] cnt_r;
  logic               pop;

  function automatic logic [FIFO_PW-1:0] ptr_inc(input logic [FIFO_PW-1:0] p);
    ptr_inc = (p == FIFO_PW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign pop              = out_ch.valid && out_ch.ready;
  assign out_ch.valid     = (cnt_r != '0);
  assign out_ch.kind      = kind_r[head_r];
  assign out_ch.bin_value = value_r[head_r];
  assign count            = cnt_r;

  always_ff @(posedge clk) begin
    if (push.valid) begin
      kind_r[tail_r]  <= push.kind;
      value_r[tail_r] <= push.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push.valid) begin
        tail_r <= ptr_inc(tail_r);
      end
      if (pop) begin
        head_r <= ptr_inc(head_r);
      end
      case ({push.valid, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ----- hdl/region_spectrum_accumulator.sv -----
// ----------------------------------------------------------------------------
// region_spectrum_accumulator
// Pixel record stream parser summing a spectrum for a selected rectangle.
// ----------------------------------------------------------------------------
// Channels: in_ch takes one word per handshake (func 0 clear, 1 stream word,
// 2 read bin); out_ch returns bin read data (kind 0) or the end-of-stream
// marker (kind 1); cfg_ch writes the rectangle edges x_low, x_high, y_low,
// y_high at indexes 0..3 and is always ready.
// Throughput: one word per cycle while in_ch.ready is high. Each word does
// at most one read-modify-write of the bin memory (registered read, write
// from the next stage); a write to the bin being read in the same cycle is
// forwarded. Results leave the registered store stage into the out_ch queue.
// Reset and clear: after reset and after each clear word the memory is swept
// to zero, one bin per cycle across all bins; in_ch.ready stays low meanwhile.
// Stall: results wait in a three-entry queue; in_ch.ready drops during the
// sweep and whenever that queue and the word in flight could fill it.
// ----------------------------------------------------------------------------
module region_spectrum_accumulator (
  input  logic      clk,
  input  logic      rst_n,
  rsa_in_if.sink    in_ch,
  rsa_out_if.source out_ch,
  rsa_cfg_if.sink   cfg_ch
);
  import rsa_pkg::*;

  req_t               req;
  res_t               res;
  stat_t              stat;
  logic [FIFO_CW-1:0] fifo_cnt;
  logic               in_acc;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !stat.busy &&
                        ((32'(fifo_cnt) + 32'(stat.res_pending)) < 32'(FIFO_DEPTH));
  assign in_acc       = in_ch.valid && in_ch.ready;

  rsa_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_ch.valid),
    .cfg_index (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .accept    (in_acc),
    .func      (in_ch.func),
    .word      (in_ch.word),
    .bin_index (in_ch.bin_index),
    .req       (req)
  );

  rsa_bin_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .res   (res),
    .stat  (stat)
  );

  rsa_out_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (res),
    .count  (fifo_cnt),
    .out_ch (out_ch)
  );

`ifndef SYNTH
  a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.func == FUNC_CLEAR) |=> !in_ch.ready)
    else $error("input accepted right after a clear word");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && fifo_cnt == FIFO_CW'(FIFO_DEPTH)) |-> (out_ch.valid && out_ch.ready))
    else $error("result queue overflow");

  a_no_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(stat.busy) && stat.busy |-> !res.valid)
    else $error("result produced during clearing sweep");
`endif

endmodule
